>>> sv/msbs_pkg.sv
// Shared types, signature table and constants for the multi-signature byte scanner.
package msbs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int NUM_SIGS    = 8;
   localparam int IDX_W       = $clog2(NUM_SIGS);
   localparam int ADDR_W      = 32;
   localparam int WIN_BYTES   = 7;
   localparam int FILL_W      = 3;
   localparam int OUT_CNT_W   = 16;

   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WIN_BYTES);
   localparam logic [FILL_W-1:0] FILL_SHORT = FILL_W'(3);

   localparam logic [ADDR_W-1:0] SHORT_BACK = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] LONG_BACK  = ADDR_W'(7);

   // Signatures packed with the first byte most significant; the short ones use bits 31:0.
   localparam logic [63:0] SIG_VALUE [NUM_SIGS] = '{
      64'h0000_0000_E9C1_FF68, 64'h0000_0000_F9C1_FF68,
      64'h0000_0000_C9CC_FF70, 64'h0000_0000_D9CC_FF70,
      64'h3960_FEE0_7DCB_60CE, 64'h3960_FEE0_7DCB_61CE,
      64'h3960_FC00_100B_60CB, 64'h3960_FC00_100B_61CB
   };
   localparam logic SIG_LONG [NUM_SIGS] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
   };

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              section_start;
      logic [ADDR_W-1:0] section_base;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]     pattern_index;
      logic [ADDR_W-1:0]    match_address;
      logic [ADDR_W-1:0]    image_offset;
      logic [OUT_CNT_W-1:0] match_count;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  index;
      logic              long_sig;
      logic [ADDR_W-1:0] cur_addr;
   } match_type;

endpackage

>>> sv/msbs_track.sv
// Byte window, running address and signature compare for the scanner.
module msbs_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  msbs_pkg::req_type   word,
   output msbs_pkg::match_type match
);
   import msbs_pkg::*;

   logic [8*WIN_BYTES-1:0] win_ff, win_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;

   logic [8*WIN_BYTES-1:0] win_cur;
   logic [FILL_W-1:0]      fill_cur;
   logic [ADDR_W-1:0]      cur_addr;
   logic [63:0]            v;
   logic                   hit;
   logic [IDX_W-1:0]       idx;

   always_comb begin
      // A section start discards the old window and restarts addressing at the new base.
      win_cur  = word.section_start ? '0 : win_ff;
      fill_cur = word.section_start ? '0 : fill_ff;
      cur_addr = word.section_start ? word.section_base : addr_ff;
      v        = {win_cur, word.data_byte};

      hit = 1'b0;
      idx = '0;
      // Walk downward so the lowest matching index takes priority.
      for (int i = NUM_SIGS - 1; i >= 0; i--) begin
         if (SIG_LONG[i]) begin
            if (fill_cur == FILL_FULL && v == SIG_VALUE[i]) begin
               hit = 1'b1;
               idx = IDX_W'(i);
            end
         end else begin
            if (fill_cur >= FILL_SHORT && v[31:0] == SIG_VALUE[i][31:0]) begin
               hit = 1'b1;
               idx = IDX_W'(i);
            end
         end
      end

      win_in  = v[8*WIN_BYTES-1:0];
      fill_in = (fill_cur == FILL_FULL) ? fill_cur : fill_cur + FILL_W'(1);
      addr_in = cur_addr + ADDR_W'(1);

      match.hit      = hit;
      match.index    = idx;
      match.long_sig = SIG_LONG[idx];
      match.cur_addr = cur_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
         addr_ff <= '0;
      end else if (adv) begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
         addr_ff <= addr_in;
      end
   end

endmodule

>>> sv/msbs_count.sv
// Saturating per-signature match counters.
module msbs_count (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               inc,
   input  logic [msbs_pkg::IDX_W-1:0]         index,
   output logic [msbs_pkg::OUT_CNT_W-1:0]     count_out
);
   import msbs_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] counts_ff [NUM_SIGS];
   logic [COUNT_WIDTH-1:0] count_in;
   logic [31:0]            count_wide;

   always_comb begin
      count_in   = (counts_ff[index] == COUNT_MAX) ? counts_ff[index]
                                                   : counts_ff[index] + COUNT_WIDTH'(1);
      count_wide = 32'(count_in);
      count_out  = count_wide[OUT_CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SIGS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (inc) begin
         counts_ff[index] <= count_in;
      end
   end

endmodule

>>> sv/multi_signature_byte_scanner.sv
// A word is first registered in the input register; its result is registered once the result side is free.
// Throughput: one word per cycle while results are taken; input stalls while a result waits to be taken.
// A word that matches no signature produces no result.
// Reset clears the window, section address, counters, image base and both valid flags.
// Reset is synchronous and active high; no clearing pass is needed afterwards.
module multi_signature_byte_scanner (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  msbs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output msbs_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [msbs_pkg::ADDR_W-1:0]     csr_wr_data
);
   import msbs_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   // Image base pre-offset by 3 and 7 (each signature length less one) so each output needs one subtract.
   logic [ADDR_W-1:0]   ib3_ff, ib3_in;
   logic [ADDR_W-1:0]   ib7_ff, ib7_in;

   logic                adv;
   match_type           match;
   logic [OUT_CNT_W-1:0] count_out;

   msbs_track u_track (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .word  (in_ff),
      .match (match)
   );

   msbs_count u_count (
      .clock     (clock),
      .reset     (reset),
      .inc       (adv && match.hit),
      .index     (match.index),
      .count_out (count_out)
   );

   always_comb begin
      adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || adv;

      in_valid_in = (req_valid && req_ready) ? 1'b1 : (adv ? 1'b0 : in_valid_ff);

      if (adv) begin
         rsp_valid_in = match.hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_in.pattern_index = match.index;
      rsp_in.match_address = match.cur_addr - (match.long_sig ? LONG_BACK : SHORT_BACK);
      rsp_in.image_offset  = match.cur_addr - (match.long_sig ? ib7_ff : ib3_ff);
      rsp_in.match_count   = count_out;

      ib3_in = csr_wr_data + SHORT_BACK;
      ib7_in = csr_wr_data + LONG_BACK;

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ib3_ff       <= SHORT_BACK;
         ib7_ff       <= LONG_BACK;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ib3_ff <= ib3_in;
            ib7_ff <= ib7_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (adv && match.hit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/msbs_checker.sv
// Port-level assertions for the scanner and the bind that attaches them.
module msbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input msbs_pkg::rsp_type           rsp_data,
   input logic                        csr_wr_en,
   input logic [msbs_pkg::ADDR_W-1:0] csr_wr_data
);
   import msbs_pkg::*;

   logic [ADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

   a_offset_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.match_address - rsp_data.image_offset) == base_ff)
      else $error("image offset does not match address and image base");

endmodule

bind multi_signature_byte_scanner msbs_checker u_msbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
